// ----- rtl/lcd_pkg.sv -----
// Shared types and constants for the LFU page cache directory.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package lcd_pkg;

	localparam int DEPTH      = 16;
	localparam int PAGE_SHIFT = 14;

	localparam int ADDR_W   = 48;
	localparam int TIME_W   = 32;
	localparam int USES_W   = 32;
	localparam int PAGE_W   = ADDR_W - PAGE_SHIFT;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int SCAN_W   = $clog2(DEPTH + 2);
	localparam int CAP_W    = 5;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;
	localparam int EVP_W    = 34;

	localparam logic [USES_W-1:0]   USES_MAX  = '1;
	localparam logic [SCAN_W-1:0]   SCAN_LAST = SCAN_W'(DEPTH + 1);
	localparam logic [CAP_W-1:0]    CAP_RESET = CAP_W'(16);

	localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FILL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FAIL = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [TIME_W-1:0] now;
		logic              fill_ok;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic                evicted;
		logic [EVP_W-1:0]    evicted_page;
		logic [ADDR_W-1:0]   page_base;
	} rsp_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [USES_W-1:0] uses;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	// Search token passed from cell to cell: first hit and best victim so far.
	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  hit_idx;
		logic [USES_W-1:0] uses;
		logic [TIME_W-1:0] stamp;
		logic [IDX_W-1:0]  vidx;
		logic [PAGE_W-1:0] vpage;
	} token_t;

	// Update command broadcast to all cells in the apply cycle.
	typedef struct packed {
		logic              bump;
		logic [IDX_W-1:0]  hit_idx;
		logic              shift;
		logic [IDX_W-1:0]  vidx;
		logic              wr_en;
		logic [IDX_W-1:0]  wr_pos;
		logic [PAGE_W-1:0] page;
		logic [TIME_W-1:0] now;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/lfu_page_cache_directory.sv -----
// Top level of the LFU page cache directory: control, registers and the cell row.
// Depends on lcd_pkg and lcd_cell.
//
// Usage: a request is taken at a rising edge with start high and busy low. Its
// page number is searched for in a row of DEPTH cells; a search token walks
// down the row one cell per cycle, picking up the first matching entry and the
// least used, oldest entry as the eviction victim. When the token leaves the
// last cell, the apply cycle performs the update: a hit bumps the use count, a miss
// with the directory full removes the victim and shifts later entries down,
// and a successful fill is appended with a use count of one.
// The result appears on rsp once the token has walked the cell row and the apply
// cycle has run; busy is high until then. The result is on rsp for one cycle with
// done high, and busy is already low in that cycle, so the next request can be
// taken at the edge that ends it. The receiver cannot stall; it must take the
// result when done is high. The capacity register is written over the cfg
// channel while the block is idle; cfg_ready is low while busy. Reset empties
// the directory and sets capacity to 16; entry contents need no clearing.
`default_nettype none

module lfu_page_cache_directory
	import lcd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire req_t             req,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data,
	output logic                  done,
	output rsp_t                  rsp
);

	logic             busy_q;
	logic             done_q;
	logic [SCAN_W-1:0] scan_q;
	logic [CNT_W-1:0] count_q;
	logic [CAP_W-1:0] cap_q;
	req_t             req_q;
	rsp_t             rsp_q;

	logic [PAGE_W-1:0] page;
	logic [CNT_W-1:0]  eff_cap;
	logic              apply;
	logic              hit;
	logic              evict;
	logic              fill;
	logic [CNT_W-1:0]  cnt_after;
	cell_ctl_t         ctl;
	token_t            tok [DEPTH+1];
	entry_t            ent [DEPTH];
	token_t            tail;

	assign page = req_q.address[ADDR_W-1:PAGE_SHIFT];

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (int'(cap_q) > DEPTH) begin
			eff_cap = CNT_W'(DEPTH);
		end else begin
			eff_cap = CNT_W'(cap_q);
		end
	end

	always_comb begin
		tok[0].hit     = 1'b0;
		tok[0].hit_idx = '0;
		tok[0].uses    = USES_MAX;
		tok[0].stamp   = req_q.now;
		tok[0].vidx    = '0;
		tok[0].vpage   = ent[0].page;
	end

	assign tail      = tok[DEPTH];
	assign apply     = busy_q && (scan_q == SCAN_LAST);
	assign hit       = tail.hit;
	assign evict     = !hit && (count_q >= eff_cap) && (count_q != '0);
	assign cnt_after = count_q - CNT_W'(evict);
	assign fill      = !hit && req_q.fill_ok && (int'(cnt_after) < DEPTH);

	always_comb begin
		ctl.bump    = apply && hit;
		ctl.hit_idx = tail.hit_idx;
		ctl.shift   = apply && evict;
		ctl.vidx    = tail.vidx;
		ctl.wr_en   = apply && fill;
		ctl.wr_pos  = IDX_W'(cnt_after);
		ctl.page    = page;
		ctl.now     = req_q.now;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lcd_cell u_cell (
			.clk      (clk),
			.pos      (IDX_W'(i)),
			.count    (count_q),
			.page     (page),
			.ctl      (ctl),
			.tok_in   (tok[i]),
			.next_ent (ent[(i + 1 < DEPTH) ? i + 1 : i]),
			.ent      (ent[i]),
			.tok_out  (tok[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			scan_q  <= '0;
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			done_q <= apply;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				scan_q <= '0;
			end else if (apply) begin
				busy_q <= 1'b0;
				if (!hit) begin
					count_q <= cnt_after + CNT_W'(fill);
				end
			end else if (busy_q) begin
				scan_q <= scan_q + SCAN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			req_q <= req;
		end
		if (apply) begin
			rsp_q.status       <= hit ? ST_HIT : (fill ? ST_FILL : ST_FAIL);
			rsp_q.slot         <= hit ? SLOT_W'(tail.hit_idx) :
				(fill ? SLOT_W'(cnt_after) : '0);
			rsp_q.evicted      <= evict;
			rsp_q.evicted_page <= evict ? EVP_W'(tail.vpage) : '0;
			rsp_q.page_base    <= {page, {PAGE_SHIFT{1'b0}}};
		end
	end

	assign busy      = busy_q;
	assign cfg_ready = !busy_q;
	assign done      = done_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/lcd_cell.sv -----
// One directory entry with its stage of the hit and victim search chain.
// Depends on lcd_pkg.
`default_nettype none

module lcd_cell
	import lcd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic [IDX_W-1:0] pos,
	input  wire logic [CNT_W-1:0] count,
	input  wire logic [PAGE_W-1:0] page,
	input  wire cell_ctl_t        ctl,
	input  wire token_t           tok_in,
	input  wire entry_t           next_ent,
	output entry_t                ent,
	output token_t                tok_out
);

	entry_t ent_q;
	token_t tok_q;
	logic   live;
	logic   lower;
	token_t tok_d;

	assign live  = CNT_W'(pos) < count;
	assign lower = live && ((ent_q.uses < tok_in.uses) ||
		((ent_q.uses == tok_in.uses) && (ent_q.stamp < tok_in.stamp)));

	always_comb begin
		tok_d = tok_in;
		if (live && !tok_in.hit && (ent_q.page == page)) begin
			tok_d.hit     = 1'b1;
			tok_d.hit_idx = pos;
		end
		if (lower) begin
			tok_d.uses  = ent_q.uses;
			tok_d.stamp = ent_q.stamp;
			tok_d.vidx  = pos;
			tok_d.vpage = ent_q.page;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
		if (ctl.wr_en && (pos == ctl.wr_pos)) begin
			ent_q.page  <= ctl.page;
			ent_q.uses  <= USES_W'(1);
			ent_q.stamp <= ctl.now;
		end else if (ctl.bump && (pos == ctl.hit_idx)) begin
			if (ent_q.uses != USES_MAX) begin
				ent_q.uses <= ent_q.uses + USES_W'(1);
			end
			ent_q.stamp <= ctl.now;
		end else if (ctl.shift && (pos >= ctl.vidx)) begin
			ent_q <= next_ent;
		end
	end

	assign ent     = ent_q;
	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ----- rtl/lcd_checker.sv -----
// Port-level checks on the LFU page cache directory, bound to the top level.
// Depends on lcd_pkg and lfu_page_cache_directory.
`default_nettype none

module lcd_checker
	import lcd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire rsp_t rsp
);

	// An accepted request keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// The block leaves busy exactly when it presents a result.
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// A result is a single-cycle strobe.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// A hit never evicts, and a failed fill reports slot zero.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == ST_HIT) |-> !rsp.evicted)
		else $error("hit reported an eviction");

	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == ST_FAIL) |-> (rsp.slot == '0))
		else $error("failed fill reported a nonzero slot");

endmodule

bind lfu_page_cache_directory lcd_checker u_lcd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

`default_nettype wire

// ----- tb/tb_lfu_page_cache_directory.sv -----
// Testbench for lfu_page_cache_directory: directed and random page requests are checked
// against a behavioral copy of the directory, under several capacity settings and idle gaps.
// Depends on lcd_pkg and the block's RTL.
`default_nettype none

module tb_lfu_page_cache_directory;
	import lcd_pkg::*;

	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 200;
	localparam int POOL_SIZE    = 24;
	localparam int MAX_GAP      = 24;
	localparam int DRAIN_CYCLES = DEPTH + 6;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	req_t             req       = '0;
	logic             cfg_valid = 1'b0;
	logic [CAP_W-1:0] cfg_data  = '0;
	logic             busy;
	logic             cfg_ready;
	logic             done;
	rsp_t             rsp;

	always #5 clk = ~clk;

	lfu_page_cache_directory dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.rsp       (rsp)
	);

	logic [PAGE_W-1:0] dir_page  [DEPTH];
	logic [USES_W-1:0] dir_uses  [DEPTH];
	logic [TIME_W-1:0] dir_stamp [DEPTH];
	int                dir_count;
	logic [CAP_W-1:0]  dir_capacity;

	rsp_t pending_rsp[$];
	rsp_t want_rsp;
	int   mismatches = 0;
	int   requests_sent = 0;
	int   results_checked = 0;
	int   capacity_writes = 0;
	int   idle_pct = 0;

	function automatic rsp_t lookup_and_update(req_t r);
		rsp_t              o;
		logic [PAGE_W-1:0] pg;
		int                limit;
		int                victim;
		logic [USES_W-1:0] best_uses;
		logic [TIME_W-1:0] best_stamp;
		pg = r.address[ADDR_W-1:PAGE_SHIFT];
		o = '0;
		o.page_base = {pg, {PAGE_SHIFT{1'b0}}};
		for (int i = 0; i < dir_count; i++) begin
			if (dir_page[i] == pg) begin
				if (dir_uses[i] != USES_MAX) dir_uses[i] = dir_uses[i] + USES_W'(1);
				dir_stamp[i] = r.now;
				o.status = ST_HIT;
				o.slot = SLOT_W'(i);
				return o;
			end
		end
		limit = (dir_capacity == 0) ? 1 : ((dir_capacity > DEPTH) ? DEPTH : int'(dir_capacity));
		if (dir_count >= limit && dir_count > 0) begin
			victim = 0;
			best_uses = USES_MAX;
			best_stamp = r.now;
			for (int i = 0; i < dir_count; i++) begin
				if (dir_uses[i] < best_uses ||
				    (dir_uses[i] == best_uses && dir_stamp[i] < best_stamp)) begin
					victim = i;
					best_uses = dir_uses[i];
					best_stamp = dir_stamp[i];
				end
			end
			o.evicted = 1'b1;
			o.evicted_page = EVP_W'(dir_page[victim]);
			for (int i = victim; i + 1 < dir_count; i++) begin
				dir_page[i] = dir_page[i + 1];
				dir_uses[i] = dir_uses[i + 1];
				dir_stamp[i] = dir_stamp[i + 1];
			end
			dir_count--;
		end
		if (r.fill_ok && dir_count < DEPTH) begin
			dir_page[dir_count] = pg;
			dir_uses[dir_count] = USES_W'(1);
			dir_stamp[dir_count] = r.now;
			o.status = ST_FILL;
			o.slot = SLOT_W'(dir_count);
			dir_count++;
		end else begin
			o.status = ST_FAIL;
			o.slot = '0;
		end
		return o;
	endfunction

	// The request stays on the port until the block takes it; start is left high afterwards
	// unless an idle gap follows.
	task automatic send_req(input req_t r);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		pending_rsp.push_back(lookup_and_update(r));
		requests_sent++;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
		end
	endtask

	task automatic send_fields(input logic [ADDR_W-1:0] a, input logic [TIME_W-1:0] t,
	                           input logic f);
		req_t r;
		r.address = a;
		r.now = t;
		r.fill_ok = f;
		send_req(r);
	endtask

	task automatic finish_requests();
		start <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		finish_requests();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dir_capacity = v;
		capacity_writes++;
	endtask

	task automatic report_mismatch(input string what, input rsp_t want, input rsp_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: want status %0d slot %0d evicted %0b page %h base %h,",
			         $time, what, want.status, want.slot, want.evicted, want.evicted_page,
			         want.page_base);
			$display("    got status %0d slot %0d evicted %0b page %h base %h",
			         got.status, got.slot, got.evicted, got.evicted_page, got.page_base);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("result with no request pending", '0, rsp);
			end else begin
				want_rsp = pending_rsp.pop_front();
				results_checked++;
				if (rsp.status !== want_rsp.status || rsp.slot !== want_rsp.slot ||
				    rsp.evicted !== want_rsp.evicted ||
				    rsp.evicted_page !== want_rsp.evicted_page ||
				    rsp.page_base !== want_rsp.page_base)
					report_mismatch("result mismatch", want_rsp, rsp);
			end
		end
	end

	function automatic logic [ADDR_W-1:0] page_addr(input int unsigned pg);
		return ADDR_W'(64'(pg) << PAGE_SHIFT);
	endfunction

	task automatic test_fill_and_hit();
		send_fields('0, '0, 1'b1);
		send_fields('1, '1, 1'b1);
		send_fields(48'h0000_0000_3FFF, 32'd5, 1'b1);
		send_fields(48'hFFFF_FFFF_C000, 32'd6, 1'b0);
	endtask

	task automatic test_fill_failure();
		send_fields(48'h1234_5678_9ABC, 32'd7, 1'b0);
		send_fields(48'h1234_5678_8000, 32'd8, 1'b0);
	endtask

	// A capacity of zero behaves as one, so every miss evicts.
	task automatic test_capacity_clamp();
		write_capacity(5'd0);
		send_fields(page_addr(1), 32'd9, 1'b1);
		send_fields(page_addr(2), 32'd10, 1'b0);
		send_fields(page_addr(3), 32'd11, 1'b1);
		write_capacity(5'd31);
	endtask

	// Equal use counts fall back to the oldest stamp and then to the lowest position.
	task automatic test_victim_ties();
		for (int k = 4; k < 7; k++) send_fields(page_addr(k), 32'd3, 1'b1);
		write_capacity(5'd4);
		send_fields(page_addr(7), 32'd12, 1'b1);
		send_fields(page_addr(3) | 48'h155, 32'd13, 1'b1);
		send_fields(page_addr(7), 32'd13, 1'b1);
		send_fields(page_addr(8), 32'd13, 1'b1);
	endtask

	// Lowering capacity below the fill level evicts only one entry per miss.
	task automatic test_capacity_shrink();
		write_capacity(5'd16);
		for (int k = 9; k < 12; k++) send_fields(page_addr(k), 32'hFFFF_FFF0, 1'b1);
		write_capacity(5'd2);
		send_fields(page_addr(12), 32'd14, 1'b1);
		send_fields(page_addr(13), 32'd15, 1'b0);
		send_fields(page_addr(9), 32'd16, 1'b0);
	endtask

	task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int pct);
		logic [PAGE_W-1:0] pool[POOL_SIZE];
		logic [TIME_W-1:0] clock_now;
		req_t              r;
		write_capacity(cap);
		idle_pct = pct;
		for (int k = 0; k < POOL_SIZE; k++) pool[k] = PAGE_W'({$urandom, $urandom});
		pool[0] = '1;
		pool[1] = '0;
		clock_now = $urandom;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if ($urandom_range(99) < 75)
				r.address = {pool[$urandom_range(POOL_SIZE - 1)], PAGE_SHIFT'($urandom)};
			else
				r.address = ADDR_W'({$urandom, $urandom});
			if ($urandom_range(9) == 0)
				clock_now = $urandom;
			else
				clock_now = clock_now + TIME_W'($urandom_range(0, 3));
			r.now = clock_now;
			r.fill_ok = ($urandom_range(99) < 85);
			send_req(r);
		end
		idle_pct = 0;
	endtask

	initial begin
		logic [CAP_W-1:0] caps[PHASES];
		int               pcts[PHASES];
		caps = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd1, 5'd9, 5'd17, 5'd2};
		pcts = '{0, 55, 15, 0, 55, 15, 55, 0};
		dir_count = 0;
		dir_capacity = CAP_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_and_hit();
		test_fill_failure();
		test_capacity_clamp();
		test_victim_ties();
		test_capacity_shrink();
		for (int p = 0; p < PHASES; p++) test_random_traffic(caps[p], pcts[p]);
		finish_requests();
		$display("Sent %0d page requests across %0d capacity writes (0 to 31),",
		         requests_sent, capacity_writes);
		$display("idle gaps 0/15/55 percent; compared %0d results, %0d mismatches.",
		         results_checked, mismatches);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Watchdog expired with %0d results outstanding.", pending_rsp.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/lcd_pkg.sv
rtl/lcd_cell.sv
rtl/lfu_page_cache_directory.sv
rtl/lcd_checker.sv
tb/tb_lfu_page_cache_directory.sv
